// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/gpx_pkg.sv =====
// ----------------------------------------------------------------------------
// gpx_pkg
// shared types, character codes and header table of the position extractor
// ----------------------------------------------------------------------------
package gpx_pkg;

	typedef logic [7:0] char_t;

	// character codes
	localparam char_t CR_CHAR    = 8'h0D;
	localparam char_t LF_CHAR    = 8'h0A;
	localparam char_t COMMA_CHAR = 8'h2C;

	// sentence header and comma positions of the two groups
	localparam int HDR_LEN       = 7;
	localparam int COMMA_MAX     = 15;
	localparam int GRP_FIRST_CNT = 3;
	localparam int GRP_LAST_CNT  = 6;
	localparam int SEP_COMMA     = 5;
	localparam int END_COMMA     = 7;

	// command queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_SEP,
		CMD_EOL,
		CMD_SEP_EOL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		char_t     ch;
	} cmd_t;

	typedef enum logic {
		BK_RUN,
		BK_EOL_NEXT
	} back_state_t;

	// expected header byte at a line position
	function automatic char_t hdr_char(input logic [2:0] idx);
		char_t c;
		unique case (idx)
			3'd0: c = 8'h24; // '$'
			3'd1: c = 8'h47; // 'G'
			3'd2: c = 8'h50; // 'P'
			3'd3: c = 8'h52; // 'R'
			3'd4: c = 8'h4D; // 'M'
			3'd5: c = 8'h43; // 'C'
			3'd6: c = 8'h2C; // ','
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/gpx_in_if.sv =====
// ----------------------------------------------------------------------------
// gpx_in_if
// byte channel carrying received nmea text
// ----------------------------------------------------------------------------
interface gpx_in_if;
	logic            valid;
	logic            ready;
	gpx_pkg::char_t  in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

// ===== hdl/gpx_out_if.sv =====
// ----------------------------------------------------------------------------
// gpx_out_if
// result channel carrying position characters and the line end marker
// ----------------------------------------------------------------------------
interface gpx_out_if;
	logic            valid;
	logic            ready;
	gpx_pkg::char_t  out_char;
	logic            end_of_line;

	modport source (output valid, output out_char, output end_of_line, input ready);
	modport sink   (input valid, input out_char, input end_of_line, output ready);
endinterface

// ===== hdl/gprmc_position_extractor.sv =====
// ----------------------------------------------------------------------------
// gprmc_position_extractor: pulls latitude and longitude out of rmc sentences
// takes one byte per cycle unless the queue is full; result items are registered
// line end gives marker, after separator if none sent; 4-entry queue sets stall
// asynchronous reset clears line state, queue pointers and output valid at once
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gprmc_position_extractor
	import gpx_pkg::*;
#(
	parameter int MAX_LINE  = 128,
	parameter int MAX_GROUP = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gpx_in_if.sink     nmea,
	gpx_out_if.source  position
);

	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_push;
	logic cmd_pop;
	logic fifo_full;
	logic fifo_empty;

	// classify bytes and track line state
	gpx_front #(
		.MAX_LINE  (MAX_LINE),
		.MAX_GROUP (MAX_GROUP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.nmea      (nmea),
		.cmd       (cmd_in),
		.cmd_push  (cmd_push),
		.fifo_full (fifo_full)
	);

	// decouple front from output stalls
	gpx_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	// emit result items
	gpx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (cmd_head),
		.fifo_empty (fifo_empty),
		.cmd_pop    (cmd_pop),
		.position   (position)
	);

	// checks
	`ASSERT_IMPLY(a_push_has_room, clk, arst_n, cmd_push, !fifo_full)
	`ASSERT_IMPLY(a_pop_has_data, clk, arst_n, cmd_pop, !fifo_empty)
	`ASSERT_NEXT(a_sep_before_eol, clk, arst_n, cmd_pop && cmd_head.kind == CMD_SEP_EOL, position.valid && !position.end_of_line && position.out_char == COMMA_CHAR)

endmodule

// ===== hdl/gpx_front.sv =====
// ----------------------------------------------------------------------------
// gpx_front
// accepts bytes, tracks header, commas and the one-character hold, and
// pushes one output command per byte that produces results
// ----------------------------------------------------------------------------
module gpx_front
	import gpx_pkg::*;
#(
	parameter int MAX_LINE  = 128,
	parameter int MAX_GROUP = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	gpx_in_if.sink       nmea,
	output cmd_t         cmd,
	output logic         cmd_push,
	input  logic         fifo_full
);

	localparam int LINE_W  = $clog2(MAX_LINE + 1);
	localparam int GROUP_W = $clog2(MAX_GROUP + 1);

	logic [2:0]         hdr_pos_q, hdr_pos_d;
	logic               hdr_fail_q, hdr_fail_d;
	logic [3:0]         comma_cnt_q, comma_cnt_d;
	logic [LINE_W-1:0]  line_pos_q, line_pos_d;
	char_t              held_char_q, held_char_d;
	logic               held_valid_q, held_valid_d;
	logic [GROUP_W-1:0] group_len_q, group_len_d;
	logic               sep_sent_q, sep_sent_d;

	logic accept;
	logic matched;
	char_t c;

	assign nmea.ready = !fifo_full;
	assign accept     = nmea.valid && nmea.ready;
	assign c          = nmea.in_char;
	assign matched    = (hdr_pos_q == 3'(HDR_LEN)) && !hdr_fail_q;

	// per-byte state update and command selection
	always_comb begin
		logic [3:0] cnt_inc;
		cnt_inc      = (comma_cnt_q < 4'(COMMA_MAX)) ? comma_cnt_q + 4'd1 : comma_cnt_q;
		hdr_pos_d    = hdr_pos_q;
		hdr_fail_d   = hdr_fail_q;
		comma_cnt_d  = comma_cnt_q;
		line_pos_d   = line_pos_q;
		held_char_d  = held_char_q;
		held_valid_d = held_valid_q;
		group_len_d  = group_len_q;
		sep_sent_d   = sep_sent_q;
		cmd_push     = 1'b0;
		cmd          = '{kind: CMD_CHAR, ch: held_char_q};
		if (accept && c != LF_CHAR) begin
			if (c == CR_CHAR) begin
				// line end: flush marker, clear line state
				if (line_pos_q != '0) begin
					if (matched) begin
						cmd_push = 1'b1;
						cmd      = '{kind: (sep_sent_q ? CMD_EOL : CMD_SEP_EOL), ch: '0};
					end
					hdr_pos_d    = '0;
					hdr_fail_d   = 1'b0;
					comma_cnt_d  = '0;
					line_pos_d   = '0;
					held_valid_d = 1'b0;
					group_len_d  = '0;
					sep_sent_d   = 1'b0;
				end
			end else if (line_pos_q < LINE_W'(MAX_LINE)) begin
				// header match
				if (line_pos_q < LINE_W'(HDR_LEN) && !hdr_fail_q) begin
					if (c == hdr_char(line_pos_q[2:0]))
						hdr_pos_d = hdr_pos_q + 3'd1;
					else
						hdr_fail_d = 1'b1;
				end
				line_pos_d = line_pos_q + LINE_W'(1);
				if (c == COMMA_CHAR) begin
					// field boundary
					comma_cnt_d = cnt_inc;
					if (matched && (cnt_inc == 4'(SEP_COMMA) || cnt_inc == 4'(END_COMMA))) begin
						held_valid_d = 1'b0;
						group_len_d  = '0;
						if (cnt_inc == 4'(SEP_COMMA) && !sep_sent_q) begin
							cmd_push   = 1'b1;
							cmd        = '{kind: CMD_SEP, ch: COMMA_CHAR};
							sep_sent_d = 1'b1;
						end
					end
				end else if (matched && comma_cnt_q >= 4'(GRP_FIRST_CNT)
						&& comma_cnt_q <= 4'(GRP_LAST_CNT)
						&& group_len_q < GROUP_W'(MAX_GROUP)) begin
					// group character through the hold
					cmd_push     = held_valid_q;
					cmd          = '{kind: CMD_CHAR, ch: held_char_q};
					held_char_d  = c;
					held_valid_d = 1'b1;
					group_len_d  = group_len_q + GROUP_W'(1);
				end
			end
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q    <= '0;
			hdr_fail_q   <= 1'b0;
			comma_cnt_q  <= '0;
			line_pos_q   <= '0;
			held_valid_q <= 1'b0;
			group_len_q  <= '0;
			sep_sent_q   <= 1'b0;
		end else begin
			hdr_pos_q    <= hdr_pos_d;
			hdr_fail_q   <= hdr_fail_d;
			comma_cnt_q  <= comma_cnt_d;
			line_pos_q   <= line_pos_d;
			held_valid_q <= held_valid_d;
			group_len_q  <= group_len_d;
			sep_sent_q   <= sep_sent_d;
		end
	end

	// held character payload
	always_ff @(posedge clk) begin
		held_char_q <= held_char_d;
	end

endmodule

// ===== hdl/gpx_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// gpx_cmd_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
module gpx_cmd_fifo
	import gpx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	input  logic pop,
	output cmd_t rdata,
	output logic full,
	output logic empty
);

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + FIFO_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - FIFO_CNT_W'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== hdl/gpx_back.sv =====
// ----------------------------------------------------------------------------
// gpx_back
// expands queued commands into result items through an output register
// ----------------------------------------------------------------------------
module gpx_back
	import gpx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       fifo_empty,
	output logic       cmd_pop,
	gpx_out_if.source  position
);

	back_state_t state_q, state_d;
	logic        out_valid_q;
	char_t       out_char_q;
	logic        out_eol_q;
	logic        load;
	logic        ld_valid;
	char_t       ld_char;
	logic        ld_eol;

	assign load              = !out_valid_q || position.ready;
	assign position.valid    = out_valid_q;
	assign position.out_char = out_char_q;
	assign position.end_of_line = out_eol_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_RUN: begin
				if (load && !fifo_empty && head.kind == CMD_SEP_EOL)
					state_d = BK_EOL_NEXT;
			end
			BK_EOL_NEXT: begin
				if (load)
					state_d = BK_RUN;
			end
		endcase
	end

	// queue pop and output register load
	always_comb begin
		cmd_pop  = 1'b0;
		ld_valid = 1'b0;
		ld_char  = '0;
		ld_eol   = 1'b0;
		unique case (state_q)
			BK_RUN: begin
				if (load && !fifo_empty) begin
					cmd_pop  = 1'b1;
					ld_valid = 1'b1;
					unique case (head.kind)
						CMD_CHAR:    ld_char = head.ch;
						CMD_SEP:     ld_char = COMMA_CHAR;
						CMD_EOL:     ld_eol  = 1'b1;
						CMD_SEP_EOL: ld_char = COMMA_CHAR;
					endcase
				end
			end
			BK_EOL_NEXT: begin
				if (load) begin
					ld_valid = 1'b1;
					ld_eol   = 1'b1;
				end
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= ld_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load && ld_valid) begin
			out_char_q <= ld_char;
			out_eol_q  <= ld_eol;
		end
	end

endmodule
